/* design/sorted_store_interpolation_search_unit_assert.svh */
// assertion macros for the sorted store search unit
// expects clk_i and rst_ni in the scope that uses them
`ifndef SORTED_STORE_INTERPOLATION_SEARCH_UNIT_ASSERT_SVH
`define SORTED_STORE_INTERPOLATION_SEARCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSIS_ASSERT(label, prop, msg)
`define SSIS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/ssis_pkg.sv */
// shared types and constants for the sorted store search unit
// no dependencies
package ssis_pkg;
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int CNT_W  = ADDR_W + 1;
  // divider operand widths: numerator 2|prod|+|den|, divisor 2|den|
  localparam int NUM_W  = 41;
  localparam int DEN_W  = 34;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic              func;
    logic signed [31:0] value;
    logic [6:0]        slot;
    logic [6:0]        right_bound;
    logic              last;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [6:0] found_position;
  } res_t;
endpackage

/* design/ssis_ram.sv */
// single write, single read element store with registered read data
// generic, no package dependency
module ssis_ram #(
  parameter int Depth = 128,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/ssis_div.sv */
// restoring divider, one quotient bit per cycle
// depends on ssis_pkg for operand widths
module ssis_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ssis_pkg::NUM_W-1:0] num_i,
  input  logic [ssis_pkg::DEN_W-1:0] den_i,
  output logic [ssis_pkg::NUM_W-1:0] quot_o,
  output logic                       done_o
);
  import ssis_pkg::*;

  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one trial subtraction per step
  always_comb begin
    trial  = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? trial - {1'b0, den_q} : trial;
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;
endmodule

/* design/sorted_store_interpolation_search_unit.sv */
// top level: sequencer for store loads, exchange sort and interpolation search
// depends on ssis_pkg, ssis_ram, ssis_div and the assertion header
//
// Usage: drive req_i and raise start_i; a transaction is taken at a rising
// edge with start_i high and busy_o low. A load writes one element; busy_o
// stays low unless the load is marked last. A last load sets the count to
// slot+1 and sorts the store through the single read port of the store.
// A search answers with one transaction on res_o, marked by done_o for
// exactly one cycle. A search whose bounds are out of order or beyond the
// count answers the cycle after acceptance. Each probe makes three store
// reads, one multiply and a 41-step bit-serial divide; the divide is
// skipped when both end values are equal. At most count+1 probes are
// made. The receiver cannot stall: done_o is a strobe. Reset clears the
// count and the sequencer; the store contents are undefined until loaded.
// No clearing pass is run.
module sorted_store_interpolation_search_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ssis_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output ssis_pkg::res_t res_o
);
  import ssis_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SORT_RDP = 4'd1;
  localparam logic [3:0] ST_SORT_CAP = 4'd2;
  localparam logic [3:0] ST_SORT_RDQ = 4'd3;
  localparam logic [3:0] ST_SORT_CMP = 4'd4;
  localparam logic [3:0] ST_SORT_WRP = 4'd5;
  localparam logic [3:0] ST_SRCH_RDL = 4'd6;
  localparam logic [3:0] ST_SRCH_RDR = 4'd7;
  localparam logic [3:0] ST_SRCH_MUL = 4'd8;
  localparam logic [3:0] ST_SRCH_GO  = 4'd9;
  localparam logic [3:0] ST_SRCH_DIV = 4'd10;
  localparam logic [3:0] ST_SRCH_RDP = 4'd11;
  localparam logic [3:0] ST_SRCH_CMP = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  p_q, p_d, q_q, q_d;
  logic signed [31:0] cur_q, cur_d;
  logic signed [31:0] tgt_q, tgt_d, sl_q, sl_d;
  logic [6:0]        l_q, l_d, r_q, r_d, pos_q, pos_d;
  logic [7:0]        probes_q, probes_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata_raw;
  logic signed [31:0] rdata;
  logic              accept;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quot;

  logic signed [32:0] diff, dend;
  logic signed [40:0] prod;
  logic [39:0]        an;
  logic [32:0]        ad;
  logic [6:0]         span, nl, nr;
  logic [7:0]         probes_n;

  ssis_ram #(.Depth(DEPTH), .Width(DATA_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  ssis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  assign rdata     = $signed(rdata_raw);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign div_start = (state_q == ST_SRCH_GO);

  // probe arithmetic
  always_comb begin
    span = r_q - l_q;
    diff = {tgt_q[31], tgt_q} - {sl_q[31], sl_q};
    dend = {rdata[31], rdata} - {sl_q[31], sl_q};
    prod = 41'(diff * $signed({1'b0, span}));
    an   = prod[40] ? 40'(-prod) : prod[39:0];
    ad   = dend[32] ? 33'(-dend) : dend;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    p_d      = p_q;
    q_d      = q_q;
    cur_d    = cur_q;
    tgt_d    = tgt_q;
    sl_d     = sl_q;
    l_d      = l_q;
    r_d      = r_q;
    pos_d    = pos_q;
    probes_d = probes_q;
    num_d    = num_q;
    den_d    = den_q;
    neg_d    = neg_q;
    done_d   = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = req_i.slot;
    wdata    = req_i.value;
    raddr    = p_q[ADDR_W-1:0];
    nl       = l_q;
    nr       = r_q;
    probes_n = probes_q + 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_LOAD) begin
            we = 1'b1;
            if (req_i.last) begin
              count_d = CNT_W'(req_i.slot) + 1'b1;
              p_d     = '0;
              state_d = ST_SORT_RDP;
            end
          end else begin
            tgt_d    = req_i.value;
            l_d      = req_i.slot;
            r_d      = req_i.right_bound;
            probes_d = '0;
            if (req_i.slot > req_i.right_bound ||
                CNT_W'(req_i.right_bound) >= count_q) begin
              done_d = 1'b1;
              res_d  = '0;
            end else begin
              state_d = ST_SRCH_RDL;
            end
          end
        end
      end
      // exchange sort: cur holds the running minimum for slot p
      ST_SORT_RDP: begin
        raddr   = p_q[ADDR_W-1:0];
        state_d = ST_SORT_CAP;
      end
      ST_SORT_CAP: begin
        cur_d   = rdata;
        q_d     = p_q + 1'b1;
        state_d = (p_q + 1'b1 >= count_q) ? ST_SORT_WRP : ST_SORT_RDQ;
      end
      ST_SORT_RDQ: begin
        raddr   = q_q[ADDR_W-1:0];
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (rdata < cur_q) begin
          we    = 1'b1;
          waddr = q_q[ADDR_W-1:0];
          wdata = cur_q;
          cur_d = rdata;
        end
        q_d     = q_q + 1'b1;
        state_d = (q_q + 1'b1 >= count_q) ? ST_SORT_WRP : ST_SORT_RDQ;
      end
      ST_SORT_WRP: begin
        we      = 1'b1;
        waddr   = p_q[ADDR_W-1:0];
        wdata   = cur_q;
        p_d     = p_q + 1'b1;
        state_d = (p_q + 1'b1 >= count_q) ? ST_IDLE : ST_SORT_RDP;
      end
      // search: fetch both end values
      ST_SRCH_RDL: begin
        raddr   = l_q;
        state_d = ST_SRCH_RDR;
      end
      ST_SRCH_RDR: begin
        raddr   = r_q;
        sl_d    = rdata;
        state_d = ST_SRCH_MUL;
      end
      ST_SRCH_MUL: begin
        num_d = NUM_W'({an, 1'b0}) + NUM_W'(ad);
        den_d = {ad, 1'b0};
        neg_d = prod[40] ^ dend[32];
        if (dend == '0) begin
          pos_d   = l_q;
          state_d = ST_SRCH_RDP;
        end else begin
          state_d = ST_SRCH_GO;
        end
      end
      ST_SRCH_GO: begin
        state_d = ST_SRCH_DIV;
      end
      // rounded quotient, clamped to the bounds
      ST_SRCH_DIV: begin
        if (div_done) begin
          if (neg_q) begin
            pos_d = l_q;
          end else if (div_quot > NUM_W'(span)) begin
            pos_d = r_q;
          end else begin
            pos_d = l_q + div_quot[6:0];
          end
          state_d = ST_SRCH_RDP;
        end
      end
      ST_SRCH_RDP: begin
        raddr   = pos_q;
        state_d = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        probes_d = probes_n;
        if (rdata == tgt_q) begin
          done_d  = 1'b1;
          res_d   = '{found: 1'b1, found_position: pos_q};
          state_d = ST_IDLE;
        end else begin
          if (tgt_q < rdata) begin
            nr = pos_q;
          end else begin
            nl = pos_q;
          end
          l_d = nl;
          r_d = nr;
          if ((nr - nl > 7'd1) && ({1'b0, probes_n} <= {1'b0, count_q})) begin
            state_d = ST_SRCH_RDL;
          end else begin
            done_d  = 1'b1;
            res_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    q_q      <= q_d;
    cur_q    <= cur_d;
    tgt_q    <= tgt_d;
    sl_q     <= sl_d;
    l_q      <= l_d;
    r_q      <= r_d;
    pos_q    <= pos_d;
    probes_q <= probes_d;
    num_q    <= num_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  `include "sorted_store_interpolation_search_unit_assert.svh"

  `SSIS_ASSERT(a_done_idle, !done_o || !busy_o, "result strobe while sequencer busy")
  `SSIS_ASSERT_NEXT(a_load_quick, start_i && !busy_o && req_i.func == FUNC_LOAD && !req_i.last, !busy_o, "plain load blocked the unit")
  `SSIS_ASSERT_NEXT(a_search_resp, start_i && !busy_o && req_i.func == FUNC_SEARCH, busy_o || done_o, "search dropped without result")
  `SSIS_ASSERT(a_sort_count, !(state_q == ST_SORT_RDP) || count_q != '0, "sorting an empty store")
endmodule

/* test/testbench.sv */
// self-checking testbench for the sorted store interpolation search unit
// depends on ssis_pkg and sorted_store_interpolation_search_unit
module testbench;
  import ssis_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  sorted_store_interpolation_search_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // shadow copy of the store and count
  longint     shadow_store [DEPTH];
  int         shadow_count;
  res_t       answers_due [$];
  int         mismatches;
  int         idle_cycles;
  bit         typed_pending;
  res_t       typed_answer;
  bit         idling_on;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t ex;
  } stim_row_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exchange sort of entries 0..count-1
  task automatic sort_shadow();
    longint t;
    for (int p = 0; p < shadow_count; p++) begin
      for (int q = p; q < shadow_count; q++) begin
        if (shadow_store[q] < shadow_store[p]) begin
          t = shadow_store[p];
          shadow_store[p] = shadow_store[q];
          shadow_store[q] = t;
        end
      end
    end
  endtask

  // interpolated probe, rounded half away from zero, clamped to [l, r]
  function automatic int probe_slot(longint tgt, int l, int r);
    longint sl, sr, den, prod, pos;
    longint unsigned an, ad, mag;
    bit neg;
    sl = shadow_store[l];
    sr = shadow_store[r];
    den = sr - sl;
    if (den == 0) return l;
    prod = (tgt - sl) * longint'(r - l);
    neg = (prod < 0) != (den < 0);
    an = (prod < 0) ? -prod : prod;
    ad = (den < 0) ? -den : den;
    mag = (2 * an + ad) / (2 * ad);
    pos = neg ? longint'(l) - longint'(mag) : longint'(l) + longint'(mag);
    if (pos < l) pos = l;
    if (pos > r) pos = r;
    return int'(pos);
  endfunction

  function automatic res_t search_answer(req_t rq);
    res_t a;
    longint tgt;
    int l, r, pos, probes;
    bit hit;
    tgt = longint'($signed(rq.value));
    l = rq.slot;
    r = rq.right_bound;
    a = '0;
    if (l > r || r >= shadow_count) return a;
    probes = 0;
    hit = 1'b0;
    do begin
      pos = probe_slot(tgt, l, r);
      if (shadow_store[pos] == tgt) hit = 1'b1;
      else if (tgt < shadow_store[pos]) r = pos;
      else l = pos;
      probes++;
    end while (!hit && (r - l > 1) && probes <= shadow_count);
    if (hit) begin
      a.found = 1'b1;
      a.found_position = pos[6:0];
    end
    return a;
  endfunction

  // apply one accepted transaction to the shadow state
  task automatic absorb_request(req_t rq);
    res_t a;
    if (rq.func == FUNC_LOAD) begin
      shadow_store[rq.slot] = longint'($signed(rq.value));
      if (rq.last) begin
        shadow_count = rq.slot + 1;
        sort_shadow();
      end
    end else begin
      a = search_answer(rq);
      if (typed_pending) begin
        a = typed_answer;
        typed_pending = 1'b0;
      end
      answers_due.push_back(a);
    end
  endtask

  // monitor: compare answers, then record newly accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer %b/%0d", res_o.found,
                                         res_o.found_position);
        end else begin
          res_t e;
          e = answers_due.pop_front();
          if (e.found !== res_o.found || e.found_position !== res_o.found_position) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer mismatch: expected %b/%0d got %b/%0d", e.found,
                       e.found_position, res_o.found, res_o.found_position);
          end
        end
      end
      if (start_i && !busy_o) begin
        absorb_request(req_i);
      end
      if (done_o || (start_i && !busy_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if (idle_cycles > 200000) begin
      $display("[sorted_store_interpolation_search_unit] ERROR");
      $finish;
    end
  end

  function automatic req_t load_req(logic signed [31:0] v, int s, bit lst);
    req_t rq;
    rq.func = FUNC_LOAD;
    rq.value = v;
    rq.slot = s[6:0];
    rq.right_bound = 7'($urandom_range(0, 127));
    rq.last = lst;
    return rq;
  endfunction

  function automatic req_t search_req(logic signed [31:0] v, int l, int r);
    req_t rq;
    rq.func = FUNC_SEARCH;
    rq.value = v;
    rq.slot = l[6:0];
    rq.right_bound = r[6:0];
    rq.last = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // drive one transaction and hold it until accepted, then maybe go quiet
  task automatic issue(req_t rq, bit typed = 1'b0, res_t ex = '0);
    @(negedge clk_i);
    if (typed) begin
      typed_pending = 1'b1;
      typed_answer = ex;
    end
    start_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy_o);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 40) - 20;
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  stim_row_t directed [$];
  int sent;
  int big_sets;
  int drains;

  initial begin
    res_t none;
    int n, nsearch, l, r, t;
    int order [$];
    logic [31:0] tv;
    none = '0;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    shadow_count = 0;
    mismatches = 0;
    idle_cycles = 0;
    typed_pending = 1'b0;
    idling_on = 1'b1;
    foreach (shadow_store[i]) shadow_store[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: empty store, extremes, bounds cases
    directed.push_back('{search_req(5, 0, 0), 1, none});
    directed.push_back('{load_req(32'h7fffffff, 0, 0), 0, none});
    directed.push_back('{load_req(32'h80000000, 1, 0), 0, none});
    directed.push_back('{load_req(0, 2, 0), 0, none});
    directed.push_back('{load_req(-1, 3, 1), 0, none});
    directed.push_back('{search_req(32'h80000000, 0, 3), 0, none});
    directed.push_back('{search_req(32'h7fffffff, 0, 3), 0, none});
    directed.push_back('{search_req(-1, 0, 3), 0, none});
    directed.push_back('{search_req(0, 2, 2), 1, '{1'b1, 7'd2}});
    directed.push_back('{search_req(1, 2, 2), 1, none});
    directed.push_back('{search_req(0, 2, 1), 1, none});
    directed.push_back('{search_req(0, 0, 4), 1, none});
    directed.push_back('{search_req(0, 0, 127), 1, none});
    directed.push_back('{search_req(7, 0, 3), 0, none});
    directed.push_back('{load_req(9, 0, 1), 0, none});
    directed.push_back('{search_req(9, 0, 0), 1, '{1'b1, 7'd0}});
    directed.push_back('{search_req(8, 0, 0), 1, none});
    directed.push_back('{load_req(4, 1, 0), 0, none});
    directed.push_back('{load_req(4, 2, 0), 0, none});
    directed.push_back('{load_req(4, 2, 1), 0, none});
    directed.push_back('{search_req(4, 0, 2), 0, none});
    directed.push_back('{search_req(5, 0, 2), 0, none});
    foreach (directed[i]) begin
      issue(directed[i].rq, directed[i].typed, directed[i].ex);
    end

    // random part: load a set, then search it
    sent = 0;
    big_sets = 0;
    drains = 0;
    while (sent < 1600) begin
      if (sent > 1400) idling_on = 1'b0;
      if (big_sets < 3 && $urandom_range(0, 30) == 0) begin
        n = $urandom_range(17, 128);
        big_sets++;
      end else n = $urandom_range(1, 16);
      order.delete();
      for (int i = 0; i < n - 1; i++) order.push_back(i);
      order.shuffle();
      tv = pick_value();
      foreach (order[i]) begin
        issue(load_req(($urandom_range(0, 3) == 0) ? tv : pick_value(), order[i], 0));
        sent++;
      end
      issue(load_req(pick_value(), n - 1, 1));
      sent++;
      nsearch = $urandom_range(3, 14);
      for (int k = 0; k < nsearch; k++) begin
        t = $urandom_range(0, 9);
        if (t < 5) tv = 32'(shadow_store[$urandom_range(0, shadow_count - 1)]);
        else tv = pick_value();
        if (t != 9) begin
          l = $urandom_range(0, shadow_count - 1);
          r = $urandom_range(l, shadow_count - 1);
        end else begin
          l = $urandom_range(0, 127);
          r = $urandom_range(0, 127);
        end
        issue(search_req(tv, l, r));
        sent++;
        // stray loads to random slots, inside or beyond the current set
        if ($urandom_range(0, 12) == 0) begin
          issue(load_req(pick_value(), $urandom_range(0, 127), 0));
          sent++;
        end
      end
      // hold off until the unit has answered everything
      if ((big_sets == 1 && n > 16) || drains == 0) begin
        drains++;
        @(negedge clk_i);
        start_i <= 1'b0;
        wait (answers_due.size() == 0);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("[sorted_store_interpolation_search_unit] OK");
    end else begin
      $display("[sorted_store_interpolation_search_unit] ERROR");
    end
    $finish;
  end
endmodule
